@@ hw/rtl/start_time_fair_queue_scheduler_unit_assert.svh @@
// assertion macros for the scheduler
`ifndef START_TIME_FAIR_QUEUE_SCHEDULER_UNIT_ASSERT_SVH
`define START_TIME_FAIR_QUEUE_SCHEDULER_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define SFQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SFQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/sfq_pkg.sv @@
// ----------------------------------------------------------------------------
// sfq_pkg
// shared types and codes of the start-time fair queuing scheduler
// ----------------------------------------------------------------------------
package sfq_pkg;

  localparam logic [1:0] ACT_ARRIVE   = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_COMPLETE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_LIMIT     = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;

  localparam logic CFG_COST  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic [15:0] COST_RESET  = 16'd100;
  localparam logic [7:0]  LIMIT_RESET = 8'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARR_TAG,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_OUT
  } sfq_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic eval;
    logic arr_tag;
    logic up_rd;
    logic up_step;
    logic up_place;
    logic pop_rd_top;
    logic pop_take;
    logic dn_rd;
    logic dn_step;
    logic dn_place;
    logic complete;
    logic set_result;
  } sfq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic full;
    logic empty;
    logic at_limit;
    logic up_done;
    logic dn_done;
  } sfq_stat_t;

endpackage

@@ hw/rtl/start_time_fair_queue_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// start_time_fair_queue_scheduler_unit
// start-time fair queuing scheduler with a binary min-heap of requests
// ----------------------------------------------------------------------------
// channel   dir  transfer
// s_axis    in   action, flow_id, request_handle
// m_axis    out  one result per item
// cfg       in   register index and write data
// after the input transfer a completion, unused code, rejected or blocked item
// goes to the result; an arrival sifts up, and a dispatch reads the top, then
// the last entry, then sifts down; each level takes a heap ram read and a compare
// a new input transfer is taken only in the idle state after each result
// synchronous reset clears counters, flow finish tags and virtual clock
// heap contents need no clearing; a stalled result holds the next item off
// ----------------------------------------------------------------------------
module start_time_fair_queue_scheduler_unit
  import sfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int FLOW_COUNT  = 16,
  parameter int TAG_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // flow_id[3:0], request_handle[19:4], zero
  input  logic [1:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // out_handle, out_flow, out_start_tag, status, queued_count
  output logic        m_axis_tuser,  // dispatched
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  sfq_cmd_t  cmd;
  sfq_stat_t stat;
  logic in_fire, res_valid;
  logic [15:0] cost;
  logic [7:0]  limit;
  logic        r_disp;
  logic [15:0] r_handle;
  logic [3:0]  r_flow;
  logic [31:0] r_tag;
  logic [2:0]  r_status;
  logic [6:0]  r_count;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cost <= COST_RESET;
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_COST) cost <= cfg_data;
      if (cfg_index == CFG_LIMIT) limit <= cfg_data[7:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (res_valid) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  sfq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_busy(m_axis_tvalid && !m_axis_tready), .stat(stat),
    .in_ready(s_axis_tready), .res_valid(res_valid), .cmd(cmd)
  );

  sfq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .FLOW_COUNT(FLOW_COUNT),
    .TAG_BITS(TAG_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_action(s_axis_tuser), .in_flow(s_axis_tdata[3:0]),
    .in_handle(s_axis_tdata[19:4]), .cost(cost), .limit(limit),
    .r_dispatched(r_disp), .r_handle(r_handle), .r_flow(r_flow), .r_tag(r_tag),
    .r_status(r_status), .r_count(r_count)
  );

  assign m_axis_tuser = r_disp;
  assign m_axis_tdata = {2'b00, r_count, r_status, r_tag, r_flow, r_handle};

`include "start_time_fair_queue_scheduler_unit_assert.svh"

  `SFQ_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `SFQ_ASSERT_NXT(a_res, res_valid, m_axis_tvalid, "result not presented")
  `SFQ_ASSERT_IMP(a_count, m_axis_tvalid, r_count <= 7'(QUEUE_DEPTH), "count overflow")
endmodule

@@ hw/rtl/sfq_ram.sv @@
// ----------------------------------------------------------------------------
// sfq_ram
// single-port write, dual-port read ram with registered read data
// ----------------------------------------------------------------------------
module sfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

@@ hw/rtl/sfq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfq_ctrl
// sequencer for arrival sift-up, dispatch sift-down and completion
// ----------------------------------------------------------------------------
module sfq_ctrl
  import sfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_busy,
  input  sfq_stat_t stat,
  output logic      in_ready,
  output logic      res_valid,
  output sfq_cmd_t  cmd
);
  sfq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_ARR_TAG;
      S_ARR_TAG: begin
        priority if (stat.action == ACT_ARRIVE && !stat.full) state_next = S_UP_RD;
        else if (stat.action == ACT_DISPATCH && !stat.at_limit && !stat.empty)
          state_next = S_POP_RD;
        else state_next = S_OUT;
      end
      S_UP_RD:   state_next = stat.up_done ? S_OUT : S_UP_CMP;
      S_UP_CMP:  state_next = S_UP_RD;
      S_POP_RD:  state_next = S_POP_LAST;
      S_POP_LAST: state_next = S_DN_RD;
      S_DN_RD:   state_next = stat.dn_done ? S_OUT : S_DN_CMP;
      S_DN_CMP:  state_next = S_DN_RD;
      S_OUT:     if (!out_busy) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load_item = in_fire;
      end
      S_ARR_TAG: begin
        cmd.eval = 1'b1;
        cmd.arr_tag = stat.action == ACT_ARRIVE && !stat.full;
        cmd.pop_rd_top = stat.action == ACT_DISPATCH;
        cmd.complete = stat.action == ACT_COMPLETE;
      end
      S_UP_RD:   if (stat.up_done) cmd.up_place = 1'b1; else cmd.up_rd = 1'b1;
      S_UP_CMP:  cmd.up_step = 1'b1;
      S_POP_RD:  cmd.pop_take = 1'b1;
      S_POP_LAST: ;
      S_DN_RD:   if (stat.dn_done) cmd.dn_place = 1'b1; else cmd.dn_rd = 1'b1;
      S_DN_CMP:  cmd.dn_step = 1'b1;
      S_OUT: begin
        if (!out_busy) begin
          cmd.set_result = 1'b1;
          res_valid = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ hw/rtl/sfq_datapath.sv @@
// ----------------------------------------------------------------------------
// sfq_datapath
// heap memories, flow finish tags, virtual clock and counters
// ----------------------------------------------------------------------------
module sfq_datapath
  import sfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int FLOW_COUNT  = 16,
  parameter int TAG_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  sfq_cmd_t    cmd,
  output sfq_stat_t   stat,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_flow,
  input  logic [15:0] in_handle,
  input  logic [15:0] cost,
  input  logic [7:0]  limit,
  output logic        r_dispatched,
  output logic [15:0] r_handle,
  output logic [3:0]  r_flow,
  output logic [31:0] r_tag,
  output logic [2:0]  r_status,
  output logic [6:0]  r_count
);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int FW = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
  localparam int EW = TAG_BITS + 20;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // wrap-aware tag order: a comes before b
  function automatic logic tag_older(input logic [TAG_BITS-1:0] a,
                                     input logic [TAG_BITS-1:0] b);
    logic [TAG_BITS-1:0] d;
    d = a - b;
    return d[TAG_BITS-1];
  endfunction

  logic [1:0]          act;
  logic [3:0]          flw;
  logic [15:0]         hnd;
  logic [CW-1:0]       count;
  logic [7:0]          outst;
  logic [TAG_BITS-1:0] vclk;
  logic [TAG_BITS-1:0] finish [FLOW_COUNT];
  logic [TAG_BITS-1:0] ins_tag;
  logic [CW-1:0]       idx;
  logic [EW-1:0]       carry;
  logic [2:0]          status;
  logic                disp;
  logic [EW-1:0]       top;
  logic                pop_d;
  logic                sift_stop;

  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [EW-1:0] wdata, qa, qb;

  sfq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_heap (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .rdata_a(qa), .raddr_b(rb), .rdata_b(qb)
  );

  logic [FW-1:0] fi;
  logic [TAG_BITS-1:0] start_c;
  logic [CW-1:0] parent;
  logic [CW:0] lch, rch, count_x;
  logic [TAG_BITS-1:0] tag_a, tag_b, tag_c;
  logic l_ok, r_ok, pick_l, pick_r;

  assign fi = (FLOW_COUNT > 1) ? FW'(flw % FLOW_COUNT) : '0;
  assign start_c = tag_older(vclk, finish[fi]) ? finish[fi] : vclk;
  assign parent = (idx - 1'b1) >> 1;
  assign lch = {idx, 1'b1};
  assign rch = {idx, 1'b0} + 2'd2;
  assign count_x = {1'b0, count};
  assign tag_a = qa[EW-1 -: TAG_BITS];
  assign tag_b = qb[EW-1 -: TAG_BITS];
  assign tag_c = carry[EW-1 -: TAG_BITS];
  assign l_ok = lch < count_x;
  assign r_ok = rch < count_x;
  // smallest of carried item and children
  assign pick_l = l_ok && tag_older(tag_a, tag_c);
  assign pick_r = r_ok && tag_older(tag_b, pick_l ? tag_a : tag_c);

  assign stat.action = act;
  assign stat.full = count >= DEPTH_C;
  assign stat.empty = count == '0;
  assign stat.at_limit = outst >= limit;
  assign stat.up_done = (idx == '0) || sift_stop;
  assign stat.dn_done = sift_stop || (lch >= count_x);

  // memory ports
  always_comb begin
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = carry;
    ra = parent[AW-1:0];
    rb = rch[AW-1:0];
    if (cmd.pop_rd_top) ra = '0;
    if (cmd.pop_take) ra = AW'(count - 1'b1);
    if (cmd.dn_rd) ra = lch[AW-1:0];
    if (cmd.up_step && tag_older(ins_tag, tag_a)) begin
      we = 1'b1;
      wdata = qa;
    end
    if (cmd.dn_step && (pick_l || pick_r)) begin
      we = 1'b1;
      wdata = pick_r ? qb : qa;
    end
    if (cmd.up_place || cmd.dn_place) we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      outst <= '0;
      vclk <= '0;
      for (int k = 0; k < FLOW_COUNT; k++) finish[k] <= '0;
      status <= ST_OK;
      disp <= 1'b0;
      pop_d <= 1'b0;
      sift_stop <= 1'b0;
      r_dispatched <= 1'b0;
      r_status <= ST_OK;
    end else begin
      pop_d <= cmd.pop_take;
      if (cmd.load_item) begin
        act <= in_action;
        flw <= in_flow;
        hnd <= in_handle;
        status <= ST_OK;
        disp <= 1'b0;
        ins_tag <= '0;
        top <= '0;
      end
      // status of the item from the counters
      if (cmd.eval) begin
        if (act == ACT_ARRIVE) status <= (count >= DEPTH_C) ? ST_FULL : ST_OK;
        if (act == ACT_DISPATCH)
          status <= (outst >= limit) ? ST_LIMIT : (count == '0) ? ST_EMPTY : ST_OK;
      end
      if (cmd.arr_tag) begin
        ins_tag <= start_c;
        finish[fi] <= start_c + TAG_BITS'(cost);
        carry <= {start_c, hnd, flw};
        idx <= count;
        count <= count + 1'b1;
        sift_stop <= 1'b0;
      end
      if (cmd.up_step) begin
        if (tag_older(ins_tag, tag_a)) idx <= parent;
        else sift_stop <= 1'b1;
      end
      if (cmd.pop_take) begin
        top <= qa;
        vclk <= tag_a;
        disp <= 1'b1;
        outst <= outst + 1'b1;
        count <= count - 1'b1;
        idx <= '0;
        sift_stop <= 1'b0;
      end
      // carry after pop is the last entry, whose read data arrives in the cycle after the pop
      if (pop_d) carry <= qa;
      if (cmd.dn_step) begin
        if (pick_l || pick_r) idx <= pick_r ? rch[CW-1:0] : lch[CW-1:0];
        else sift_stop <= 1'b1;
      end
      if (cmd.complete) begin
        if (outst == '0) status <= ST_UNDERFLOW;
        else outst <= outst - 1'b1;
      end
      if (cmd.set_result) begin
        r_dispatched <= disp;
        r_handle <= top[19:4];
        r_flow <= top[3:0];
        r_tag <= disp ? 32'(top[EW-1 -: TAG_BITS]) : 32'(ins_tag);
        r_status <= status;
        r_count <= 7'(count);
      end
    end
  end
endmodule
